@@ hw/rtl/mcfe_pkg.sv @@
// Shared types, constants and codes for the MIT-mode command frame encoder.
package mcfe_pkg;

    // Mode-switch register write frame
    localparam int unsigned MIT_MODE_CODE_DEF = 1;
    localparam logic [10:0] MODE_FRAME_ID     = 11'h7FF;
    localparam logic [7:0]  MODE_CMD_BYTE     = 8'h55;
    localparam logic [7:0]  MODE_REG_NUM      = 8'd10;
    localparam logic [7:0]  ID_LOW_MASK       = 8'hFF;
    localparam logic [7:0]  ID_HIGH_MASK      = 8'h0F;
    localparam logic [3:0]  FRAME_LEN         = 4'd8;

    // Scaling divider
    localparam int unsigned NUM_W     = 32;
    localparam int unsigned PROD_W    = 48;
    localparam int unsigned QUO_W     = 16;
    localparam int unsigned CODE_W    = 12;
    localparam int unsigned DIV_STEPS = QUO_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID,
        CFG_USE_FD,
        CFG_ZERO_OFFSET,
        CFG_POS_MAX,
        CFG_SPD_MAX,
        CFG_TAU_MAX,
        CFG_KP_MAX,
        CFG_KD_MAX
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CH_POS,
        CH_VEL,
        CH_KP,
        CH_KD,
        CH_TAU
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SCALE,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] pos_cmd;
        logic signed [31:0] vel_cmd;
        logic signed [31:0] kp_cmd;
        logic signed [31:0] kd_cmd;
        logic signed [31:0] torque_cmd;
    } in_item_t;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] payload;
        logic        brs_flag;
        logic        is_mode_write;
    } out_item_t;

    typedef struct packed {
        logic [10:0]        node_id;
        logic               use_fd;
        logic signed [31:0] zero_offset;
        logic [30:0]        pos_max;
        logic [30:0]        spd_max;
        logic [30:0]        tau_max;
        logic [30:0]        kp_max;
        logic [30:0]        kd_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        node_id:     11'd1,
        use_fd:      1'b0,
        zero_offset: 32'sd0,
        pos_max:     31'd819200,
        spd_max:     31'd1310720,
        tau_max:     31'd1835008,
        kp_max:      31'd32768000,
        kd_max:      31'd327680
    };

    typedef struct packed {
        logic  load;
        logic  mode_frame;
        logic  clamp;
        logic  scale;
        logic  div_step;
        logic  store;
        logic  emit;
        chan_t chan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

@@ hw/rtl/mcfe_cfg_regs.sv @@
// Configuration register file of the command frame encoder.
module mcfe_cfg_regs
    import mcfe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NODE_ID:     cfg_next.node_id     = cfg_wdata[10:0];
                CFG_USE_FD:      cfg_next.use_fd      = cfg_wdata[0];
                CFG_ZERO_OFFSET: cfg_next.zero_offset = cfg_wdata;
                CFG_POS_MAX:     cfg_next.pos_max     = cfg_wdata[30:0];
                CFG_SPD_MAX:     cfg_next.spd_max     = cfg_wdata[30:0];
                CFG_TAU_MAX:     cfg_next.tau_max     = cfg_wdata[30:0];
                CFG_KP_MAX:      cfg_next.kp_max      = cfg_wdata[30:0];
                CFG_KD_MAX:      cfg_next.kd_max      = cfg_wdata[30:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/mcfe_ctrl.sv @@
// Sequencing state machine: channel loop, divider step count, mode flag.
module mcfe_ctrl
    import mcfe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    state_t              state_reg, state_next;
    chan_t               chan_reg, chan_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                mode_is_mit_reg, mode_is_mit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            chan_reg        <= CH_POS;
            step_reg        <= '0;
            mode_is_mit_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            chan_reg        <= chan_next;
            step_reg        <= step_next;
            mode_is_mit_reg <= mode_is_mit_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        chan_next        = chan_reg;
        step_next        = step_reg;
        mode_is_mit_next = mode_is_mit_reg;
        cmd              = '0;
        cmd.chan         = chan_reg;
        s_ready          = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load       = 1'b1;
                    cmd.mode_frame = !mode_is_mit_reg;
                    chan_next      = CH_POS;
                    if (mode_is_mit_reg) begin
                        state_next = ST_CLAMP;
                    end else begin
                        // command dropped, mode write goes out instead
                        mode_is_mit_next = 1'b1;
                        state_next       = ST_DONE;
                    end
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (chan_reg == CH_TAU) begin
                    state_next = ST_DONE;
                end else begin
                    chan_next  = chan_t'(chan_reg + 3'd1);
                    state_next = ST_CLAMP;
                end
            end
            ST_DONE: begin
                if (!status.out_stall) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_mode_frame_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !mode_is_mit_reg) |=> (state_reg == ST_DONE))
        else $error("mode write did not go straight to output");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == STEP_LAST) |=> (state_reg == ST_STORE))
        else $error("divider ran past its step count");

    a_last_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE && chan_reg == CH_TAU) |=> (state_reg == ST_DONE))
        else $error("channel loop did not end after torque");

    a_mode_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_is_mit_reg |=> mode_is_mit_reg)
        else $error("mode flag cleared outside reset");

endmodule

@@ hw/rtl/mcfe_dpath.sv @@
// Datapath: input capture, clamp, scale, shared restoring divider, frame packing.
module mcfe_dpath
    import mcfe_pkg::*;
#(
    parameter int unsigned MIT_MODE_CODE = MIT_MODE_CODE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_cmd_t  cmd,
    input  cfg_t       cfg,
    input  in_item_t   s_payload,
    input  logic       m_ready,
    output logic       m_valid,
    output out_item_t  m_payload,
    output dp_status_t status
);

    // captured command, position already offset (33 bits)
    logic [32:0]       pos_reg;
    logic [31:0]       vel_reg, kp_reg, kd_reg, tau_reg;
    logic              mode_frame_reg;

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  span_reg;
    logic              zero_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [QUO_W-1:0]  pos_code_reg;
    logic [CODE_W-1:0] vel_code_reg, kp_code_reg, kd_code_reg, tau_code_reg;

    out_item_t         out_reg;
    logic              m_valid_reg, m_valid_next;

    // channel operand select
    logic [32:0]       x_sel;
    logic [30:0]       max_sel;
    logic              sym_sel;
    logic [33:0]       diff;
    logic [NUM_W-1:0]  span;
    logic [NUM_W-1:0]  clamped;
    logic [PROD_W-1:0] product;
    logic [NUM_W:0]    trial;
    logic              ge;
    logic [NUM_W:0]    trial_sub;
    logic [QUO_W-1:0]  code;
    out_item_t         out_next;

    always_comb begin
        unique case (cmd.chan)
            CH_POS: begin
                x_sel = pos_reg;   max_sel = cfg.pos_max; sym_sel = 1'b1;
            end
            CH_VEL: begin
                x_sel = {vel_reg[31], vel_reg}; max_sel = cfg.spd_max; sym_sel = 1'b1;
            end
            CH_KP: begin
                x_sel = {kp_reg[31], kp_reg};   max_sel = cfg.kp_max;  sym_sel = 1'b0;
            end
            CH_KD: begin
                x_sel = {kd_reg[31], kd_reg};   max_sel = cfg.kd_max;  sym_sel = 1'b0;
            end
            CH_TAU: begin
                x_sel = {tau_reg[31], tau_reg}; max_sel = cfg.tau_max; sym_sel = 1'b1;
            end
            default: begin
                x_sel = '0; max_sel = '0; sym_sel = 1'b0;
            end
        endcase
    end

    // x - lo, then clamp into 0..span
    always_comb begin
        diff = {x_sel[32], x_sel} + (sym_sel ? {3'b000, max_sel} : 34'd0);
        span = sym_sel ? {max_sel, 1'b0} : {1'b0, max_sel};
        if (diff[33]) begin
            clamped = '0;
        end else if (diff[32:0] > {1'b0, span}) begin
            clamped = span;
        end else begin
            clamped = diff[31:0];
        end
    end

    // num * full as shift and subtract
    always_comb begin
        if (cmd.chan == CH_POS) begin
            product = {num_reg, 16'd0} - {16'd0, num_reg};
        end else begin
            product = {4'd0, num_reg, 12'd0} - {16'd0, num_reg};
        end
    end

    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign ge        = (trial >= {1'b0, span_reg});
    assign trial_sub = trial - {1'b0, span_reg};
    assign code      = zero_reg ? '0 : quo_reg;

    always_comb begin
        out_next.frame_len = FRAME_LEN;
        out_next.brs_flag  = cfg.use_fd;
        if (mode_frame_reg) begin
            out_next.frame_id      = MODE_FRAME_ID;
            out_next.is_mode_write = 1'b1;
            out_next.payload       = {cfg.node_id[7:0] & ID_LOW_MASK,
                                      {5'd0, cfg.node_id[10:8]} & ID_HIGH_MASK,
                                      MODE_CMD_BYTE, MODE_REG_NUM,
                                      8'(MIT_MODE_CODE), 24'd0};
        end else begin
            out_next.frame_id      = cfg.node_id;
            out_next.is_mode_write = 1'b0;
            out_next.payload       = {pos_code_reg, vel_code_reg, kp_code_reg,
                                      kd_code_reg, tau_code_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg        <= {s_payload.pos_cmd[31], s_payload.pos_cmd}
                              - {cfg.zero_offset[31], cfg.zero_offset};
            vel_reg        <= s_payload.vel_cmd;
            kp_reg         <= s_payload.kp_cmd;
            kd_reg         <= s_payload.kd_cmd;
            tau_reg        <= s_payload.torque_cmd;
            mode_frame_reg <= cmd.mode_frame;
        end
        if (cmd.clamp) begin
            num_reg  <= clamped;
            span_reg <= span;
            zero_reg <= (max_sel == '0);
        end
        if (cmd.scale) begin
            rem_reg <= product[PROD_W-1:QUO_W];
            quo_reg <= product[QUO_W-1:0];
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? trial_sub[NUM_W-1:0] : trial[NUM_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
        if (cmd.store) begin
            unique case (cmd.chan)
                CH_POS:  pos_code_reg <= code;
                CH_VEL:  vel_code_reg <= code[CODE_W-1:0];
                CH_KP:   kp_code_reg  <= code[CODE_W-1:0];
                CH_KD:   kd_code_reg  <= code[CODE_W-1:0];
                CH_TAU:  tau_code_reg <= code[CODE_W-1:0];
                default: tau_code_reg <= tau_code_reg;
            endcase
        end
        if (cmd.emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid_next = cmd.emit || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload        = out_reg;
    assign status.out_stall = m_valid_reg && !m_ready;

endmodule

@@ hw/rtl/mit_command_frame_encoder_unit.sv @@
// Top level of the MIT-mode motor command frame encoder.
//
// Takes one hybrid motor command (position, velocity, stiffness, damping,
// torque, all signed Q15.16) per transfer and returns one CAN frame per
// transfer. Position has the zero offset taken off, each value is clamped to
// its limits (gains to 0..max) and scaled to 16 bits (position) or 12 bits
// (the rest), truncating, then packed high bits first. The first transfer
// after reset is not encoded: it is replaced by the mode-switch register
// write to id 0x7FF, after which all commands are encoded. For a command,
// five channels of clamp, scale, 16 restoring-divider steps and store run
// through one shared divider, then the frame is loaded into the output
// register. No new command is taken until the block is back in idle. The
// mode write skips the channels and goes straight to the output load.
// One command is in flight at a time; a new transfer is taken while a
// finished frame still waits in the output register, and the output load
// then stalls until that frame is taken. A limit written as zero gives a
// code of zero. Configuration is a plain write port (index per register,
// no read-back) and is only to be written while the block is idle.
module mit_command_frame_encoder_unit
    import mcfe_pkg::*;
#(
    parameter int unsigned MIT_MODE_CODE = MIT_MODE_CODE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // command input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_payload,
    // frame output
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_payload
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // limits, offsets and ids
    mcfe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer: owns the mode flag and the channel / step counters
    mcfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and output register
    mcfe_dpath #(
        .MIT_MODE_CODE (MIT_MODE_CODE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg       (cfg),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload),
        .status    (status)
    );

endmodule
